// ===== src/msm_pkg.sv =====
// Shared constants, codes and stage record types for the bit-string mutation unit.
`timescale 1ns / 1ps

package msm_pkg;

   localparam int DATA_W   = 64;
   localparam int MAX_BITS = 64;
   localparam int KIND_W   = 3;
   localparam int LEN_W    = 7;
   localparam int POS_W    = 6;
   localparam int CNT_W    = 7;
   localparam int GRP_W    = 8;
   localparam int NUM_GRP  = DATA_W / GRP_W;
   localparam int GCNT_W   = $clog2(GRP_W + 1);
   localparam int LOC_W    = $clog2(GRP_W);
   localparam int WINDOW   = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_RESET      = 3'd0,
      KIND_SET        = 3'd1,
      KIND_FLIP       = 3'd2,
      KIND_GLOBAL_MAJ = 3'd3,
      KIND_GLOBAL_MIN = 3'd4,
      KIND_LOCAL_MAJ  = 3'd5,
      KIND_LOCAL_MIN  = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [DATA_W-1:0]      orig;
      logic [DATA_W-1:0]      pmask;
      logic [DATA_W-1:0]      pfixed;
      logic [LEN_W-1:0]       length;
      logic [POS_W-1:0]       position;
   } req_type;

   // after group counts
   typedef struct packed {
      kind_type                            kind;
      logic [DATA_W-1:0]                   orig;
      logic [DATA_W-1:0]                   modmask;
      logic [DATA_W-1:0]                   base;
      logic [DATA_W-1:0]                   lmask;
      logic [POS_W-1:0]                    pos;
      logic [NUM_GRP-1:0][GCNT_W-1:0]      grp_cnt;
      logic [NUM_GRP-1:0][GCNT_W-1:0]      grp_ones;
      logic [DATA_W-1:0][LOC_W-1:0]        loc_rank;
   } s1_type;

   // after ranks and totals
   typedef struct packed {
      kind_type                            kind;
      logic [DATA_W-1:0]                   orig;
      logic [DATA_W-1:0]                   modmask;
      logic [DATA_W-1:0]                   base;
      logic [DATA_W-1:0]                   lmask;
      logic [POS_W-1:0]                    pos;
      logic [DATA_W-1:0][POS_W-1:0]        rank;
      logic [CNT_W-1:0]                    m_cnt;
      logic [CNT_W-1:0]                    ones_cnt;
   } s2_type;

   // after window placement
   typedef struct packed {
      kind_type                            kind;
      logic [DATA_W-1:0]                   orig;
      logic [DATA_W-1:0]                   modmask;
      logic [DATA_W-1:0]                   base;
      logic [DATA_W-1:0]                   lmask;
      logic [POS_W-1:0]                    pos;
      logic [DATA_W-1:0][POS_W-1:0]        rank;
      logic [CNT_W-1:0]                    m_cnt;
      logic [CNT_W-1:0]                    ones_cnt;
      logic                                bad;
      logic                                whole;
      logic [POS_W-1:0]                    win_lo;
   } s3_type;

   // after bit pick and majority vote
   typedef struct packed {
      kind_type               kind;
      logic [DATA_W-1:0]      orig;
      logic [DATA_W-1:0]      base;
      logic [DATA_W-1:0]      lmask;
      logic [DATA_W-1:0]      hit;
      logic                   bad;
      logic                   cur;
      logic                   maj;
   } s4_type;

   typedef struct packed {
      logic [DATA_W-1:0]      new_bits;
      logic                   changed;
      logic                   position_bad;
   } rsp_type;

endpackage

// ===== src/msm_req_if.sv =====
// Request channel: valid/ready plus the mutation request fields.
`timescale 1ns / 1ps

interface msm_req_if import msm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [DATA_W-1:0]   original_bits;
   logic [DATA_W-1:0]   pattern_mask;
   logic [DATA_W-1:0]   pattern_fixed;
   logic [LEN_W-1:0]    length;
   logic [POS_W-1:0]    position;

   modport source (output valid, kind, original_bits, pattern_mask, pattern_fixed,
                   length, position, input ready);
   modport sink   (input valid, kind, original_bits, pattern_mask, pattern_fixed,
                   length, position, output ready);
endinterface

// ===== src/msm_rsp_if.sv =====
// Response channel: valid/ready plus the mutated string and flags.
`timescale 1ns / 1ps

interface msm_rsp_if import msm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DATA_W-1:0]   new_bits;
   logic                changed;
   logic                position_bad;

   modport source (output valid, new_bits, changed, position_bad, input ready);
   modport sink   (input valid, new_bits, changed, position_bad, output ready);
endinterface

// ===== src/msm_count.sv =====
// Stages 1-2: length mask, per-group bit counts, then per-bit ranks and totals.
`timescale 1ns / 1ps

module msm_count import msm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output s2_type  out_data
);

   logic   v1_ff, v1_in, v2_ff, v2_in;
   logic   rdy1, rdy2;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign v1_in    = rdy1 ? in_valid : v1_ff;
   assign v2_in    = rdy2 ? v1_ff : v2_ff;

   always_comb begin
      automatic logic [LEN_W-1:0]  lenc;
      automatic logic [DATA_W-1:0] lm;
      automatic logic [DATA_W-1:0] mm;
      automatic logic [GCNT_W-1:0] c;
      automatic logic [GCNT_W-1:0] o;
      lenc = (in_data.length > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : in_data.length;
      for (int i = 0; i < DATA_W; i++) begin
         lm[i] = (LEN_W'(i) < lenc);
      end
      mm = in_data.pmask & lm;
      s1_in.kind    = in_data.kind;
      s1_in.orig    = in_data.orig;
      s1_in.modmask = mm;
      s1_in.base    = (in_data.pfixed & ~mm & lm) | (in_data.orig & mm);
      s1_in.lmask   = lm;
      s1_in.pos     = in_data.position;
      for (int g = 0; g < NUM_GRP; g++) begin
         c = '0;
         o = '0;
         for (int j = 0; j < GRP_W; j++) begin
            s1_in.loc_rank[g*GRP_W+j] = LOC_W'(c);
            c = c + GCNT_W'(mm[g*GRP_W+j]);
            o = o + GCNT_W'(mm[g*GRP_W+j] & in_data.orig[g*GRP_W+j]);
         end
         s1_in.grp_cnt[g]  = c;
         s1_in.grp_ones[g] = o;
      end
   end

   always_comb begin
      automatic logic [CNT_W-1:0] acc;
      automatic logic [CNT_W-1:0] ones;
      acc  = '0;
      ones = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         for (int j = 0; j < GRP_W; j++) begin
            s2_in.rank[g*GRP_W+j] = POS_W'(acc + CNT_W'(s1_ff.loc_rank[g*GRP_W+j]));
         end
         acc  = acc + CNT_W'(s1_ff.grp_cnt[g]);
         ones = ones + CNT_W'(s1_ff.grp_ones[g]);
      end
      s2_in.kind     = s1_ff.kind;
      s2_in.orig     = s1_ff.orig;
      s2_in.modmask  = s1_ff.modmask;
      s2_in.base     = s1_ff.base;
      s2_in.lmask    = s1_ff.lmask;
      s2_in.pos      = s1_ff.pos;
      s2_in.m_cnt    = acc;
      s2_in.ones_cnt = ones;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

endmodule

// ===== src/msm_select.sv =====
// Stages 3-4: bad-position check and window placement, then bit pick and majority vote.
`timescale 1ns / 1ps

module msm_select import msm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  s2_type  in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output s4_type  out_data
);

   logic   v3_ff, v3_in, v4_ff, v4_in;
   logic   rdy3, rdy4;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;

   assign rdy4     = !v4_ff || out_ready;
   assign rdy3     = !v3_ff || rdy4;
   assign in_ready = rdy3;
   assign v3_in    = rdy3 ? in_valid : v3_ff;
   assign v4_in    = rdy4 ? v3_ff : v4_ff;

   always_comb begin
      automatic logic [POS_W-1:0] lo;
      automatic logic [CNT_W-1:0] top;
      automatic logic             glob;
      glob = (in_data.kind == KIND_GLOBAL_MAJ) || (in_data.kind == KIND_GLOBAL_MIN);
      lo   = (in_data.pos == '0) ? '0 : in_data.pos - POS_W'(1);
      top  = in_data.m_cnt - CNT_W'(WINDOW);
      s3_in.whole = glob || (in_data.m_cnt <= CNT_W'(WINDOW));
      // pull the window inward at the upper end
      if (!s3_in.whole && (CNT_W'(lo) > top)) begin
         lo = POS_W'(top);
      end
      s3_in.win_lo   = lo;
      s3_in.bad      = CNT_W'(in_data.pos) >= in_data.m_cnt;
      s3_in.kind     = in_data.kind;
      s3_in.orig     = in_data.orig;
      s3_in.modmask  = in_data.modmask;
      s3_in.base     = in_data.base;
      s3_in.lmask    = in_data.lmask;
      s3_in.pos      = in_data.pos;
      s3_in.rank     = in_data.rank;
      s3_in.m_cnt    = in_data.m_cnt;
      s3_in.ones_cnt = in_data.ones_cnt;
   end

   always_comb begin
      automatic logic [WINDOW-1:0] win;
      automatic logic [CNT_W:0]    twice;
      automatic logic              cur;
      win = '0;
      for (int i = 0; i < DATA_W; i++) begin
         s4_in.hit[i] = s3_ff.modmask[i] && (s3_ff.rank[i] == s3_ff.pos);
         for (int j = 0; j < WINDOW; j++) begin
            if (s3_ff.modmask[i] && s3_ff.orig[i]
                && (s3_ff.rank[i] == POS_W'(s3_ff.win_lo + POS_W'(j)))) begin
               win[j] = 1'b1;
            end
         end
      end
      cur   = |(s4_in.hit & s3_ff.orig);
      twice = {s3_ff.ones_cnt, 1'b0};
      if (s3_ff.whole) begin
         if (twice > {1'b0, s3_ff.m_cnt}) begin
            s4_in.maj = 1'b1;
         end else if (twice < {1'b0, s3_ff.m_cnt}) begin
            s4_in.maj = 1'b0;
         end else begin
            s4_in.maj = cur;
         end
      end else begin
         // full three-bit window never ties
         s4_in.maj = (win[0] & win[1]) | (win[0] & win[2]) | (win[1] & win[2]);
      end
      s4_in.cur   = cur;
      s4_in.kind  = s3_ff.kind;
      s4_in.orig  = s3_ff.orig;
      s4_in.base  = s3_ff.base;
      s4_in.lmask = s3_ff.lmask;
      s4_in.bad   = s3_ff.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_ff <= s3_in;
      end
      if (rdy4) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

// ===== src/msm_merge.sv =====
// Stage 5: apply the operation, merge into the string, flag changes; output register.
`timescale 1ns / 1ps

module msm_merge import msm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  s4_type  in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    v5_ff, v5_in;
   logic    rdy5;
   rsp_type r_ff, r_in;

   assign rdy5     = !v5_ff || out_ready;
   assign in_ready = rdy5;
   assign v5_in    = rdy5 ? in_valid : v5_ff;

   always_comb begin
      automatic logic              nb;
      automatic logic [DATA_W-1:0] res;
      unique case (in_data.kind) inside
         KIND_RESET:                         nb = 1'b0;
         KIND_SET:                           nb = 1'b1;
         KIND_FLIP:                          nb = !in_data.cur;
         KIND_GLOBAL_MAJ, KIND_LOCAL_MAJ:    nb = in_data.maj;
         KIND_GLOBAL_MIN, KIND_LOCAL_MIN:    nb = !in_data.maj;
         default:                            nb = in_data.cur;
      endcase
      if (in_data.bad) begin
         res = in_data.orig & in_data.lmask;
      end else begin
         res = (in_data.base & ~in_data.hit) | (nb ? in_data.hit : '0);
      end
      r_in.new_bits     = res;
      r_in.changed      = !in_data.bad && (|((res ^ in_data.orig) & in_data.lmask));
      r_in.position_bad = in_data.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v5_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         r_ff <= r_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data  = r_ff;

endmodule

// ===== src/masked_bitstring_mutation_unit.sv =====
// Top level of the masked bit-string mutation unit.
//
//   channel   dir   handshake        beat contents
//   req_bus   in    valid / ready    kind, original_bits, pattern_mask, pattern_fixed,
//                                    length, position
//   rsp_bus   out   valid / ready    new_bits, changed, position_bad
//
// Five register stages: group counts, ranks, window placement, bit pick and vote,
// merge into the output register. One beat per cycle in while the response side does not stall.
// Each stage has its own valid bit and loads whenever it is empty or the next
// stage moves, so bubbles close up behind a stalled response.
// Synchronous reset clears the valid bits only.
`timescale 1ns / 1ps

module masked_bitstring_mutation_unit import msm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   msm_req_if.sink    req_bus,
   msm_rsp_if.source  rsp_bus
);

   req_type req_data;
   s2_type  s2_data;
   s4_type  s4_data;
   rsp_type rsp_data;
   logic    s2_valid, s2_ready, s4_valid, s4_ready;

   assign req_data.kind     = kind_type'(req_bus.kind);
   assign req_data.orig     = req_bus.original_bits;
   assign req_data.pmask    = req_bus.pattern_mask;
   assign req_data.pfixed   = req_bus.pattern_fixed;
   assign req_data.length   = req_bus.length;
   assign req_data.position = req_bus.position;

   msm_count u_count (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (req_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   msm_select u_select (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s4_valid),
      .out_ready (s4_ready),
      .out_data  (s4_data)
   );

   msm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_valid),
      .in_ready  (s4_ready),
      .in_data   (s4_data),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   assign rsp_bus.new_bits     = rsp_data.new_bits;
   assign rsp_bus.changed      = rsp_data.changed;
   assign rsp_bus.position_bad = rsp_data.position_bad;

endmodule
